// ----- rtl/eci_pkg.sv -----
// Shared types and constants for the easing curve interpolator.
package eci_pkg;

  localparam int FRAC_BITS_DEF      = 16;
  localparam int SINE_ROM_DEPTH_DEF = 256;

  localparam int FRAME_W  = 16;
  localparam int AMP_W    = 31;
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int BDEN_W      = 11;

  localparam logic [MODE_W-1:0] MODE_CUBIC_INOUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUBIC_OUT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNCE_OUT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BACK_OUT    = 2'd3;

  localparam logic [1:0] REG_START_FRAME = 2'd0;
  localparam logic [1:0] REG_END_FRAME   = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE   = 2'd2;
  localparam logic [1:0] REG_CURVE_MODE  = 2'd3;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FULL,
    KIND_INTERP
  } kind_t;

  typedef struct packed {
    logic [FRAME_W-1:0]       start_frame;
    logic [FRAME_W-1:0]       end_frame;
    logic signed [AMP_W-1:0]  amplitude;
    logic [MODE_W-1:0]        curve_mode;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] offset;
    logic [FRAME_W-1:0] span;
  } item_t;

endpackage

// ----- rtl/eci_front.sv -----
// Front end: classifies each incoming frame and forms the divider operands.
module eci_front (
  input  logic                         frame_valid,
  input  logic [eci_pkg::FRAME_W-1:0]  frame_now,
  input  eci_pkg::cfg_t                cfg,
  input  logic                         queue_full,
  output logic                         frame_stall,
  output logic                         push,
  output eci_pkg::item_t               item
);

  assign frame_stall = queue_full;
  assign push        = frame_valid && !queue_full;

  always_comb begin
    item.kind   = eci_pkg::KIND_INTERP;
    item.offset = frame_now - cfg.start_frame;
    item.span   = cfg.end_frame - cfg.start_frame;
    // end test wins over start test
    if (frame_now >= cfg.end_frame) begin
      item.kind   = eci_pkg::KIND_FULL;
      item.offset = '0;
      item.span   = eci_pkg::FRAME_W'(1);
    end else if (frame_now <= cfg.start_frame) begin
      item.kind   = eci_pkg::KIND_ZERO;
      item.offset = '0;
      item.span   = eci_pkg::FRAME_W'(1);
    end
  end

endmodule

// ----- rtl/eci_fifo.sv -----
// Short item queue between the front end and the evaluation pipeline.
module eci_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eci_pkg::item_t  item_in,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output eci_pkg::item_t  item_out
);

  localparam int DEPTH = eci_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  eci_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign item_out  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  ast_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  ast_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue read while empty");
  ast_count_track: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/eci_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module eci_div #(
  parameter int DW = 16,
  parameter int QB = 16,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] num_hi,
  input  logic [QB-1:0] num_lo,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic [SW-1:0] side_out
);

  // num_hi must be below den; lo bits shift out the top, quotient bits in at the bottom
  logic          vld_r  [QB];
  logic [DW-1:0] rem_r  [QB];
  logic [QB-1:0] lo_r   [QB];
  logic [DW-1:0] den_r  [QB];
  logic [SW-1:0] side_r [QB];

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QB-1:0] lo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (g == 0) begin : g_first
      assign vld_in    = in_valid;
      assign rem_in    = num_hi;
      assign lo_in     = num_lo;
      assign den_in    = den;
      assign side_in_s = side_in;
    end else begin : g_next
      assign vld_in    = vld_r[g-1];
      assign rem_in    = rem_r[g-1];
      assign lo_in     = lo_r[g-1];
      assign den_in    = den_r[g-1];
      assign side_in_s = side_r[g-1];
    end

    assign trial = {rem_in, lo_in[QB-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g]  <= den_in;
        side_r[g] <= side_in_s;
        if (trial >= {1'b0, den_in}) begin
          rem_r[g] <= diff[DW-1:0];
          lo_r[g]  <= {lo_in[QB-2:0], 1'b1};
        end else begin
          rem_r[g] <= trial[DW-1:0];
          lo_r[g]  <= {lo_in[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign quo       = lo_r[QB-1];
  assign side_out  = side_r[QB-1];

endmodule

// ----- rtl/eci_sine_rom.sv -----
// Half-period sine table in Q1.30 with a registered two-entry read.
module eci_sine_rom #(
  parameter int DEPTH = 256,
  parameter int KW    = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [KW-1:0] k,
  output logic [30:0]   s0,
  output logic [30:0]   s1
);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TERM_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210, 64'd272};

  // sin(pi*idx/DEPTH) by a nine-term Taylor series, angle folded to [0, pi/2]
  function automatic logic [30:0] sine_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] mag;
    longint      sum;
    int          n;
    if (idx >= DEPTH) begin
      return '0;
    end
    x = (PI_Q30 * 64'(idx)) / DEPTH;
    if (x > (PI_Q30 >> 1)) begin
      x = PI_Q30 - x;
    end
    x2  = (x * x) >> 30;
    mag = x;
    sum = longint'(x);
    for (n = 1; n <= 8; n++) begin
      mag = ((mag * x2) >> 30) / TERM_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return 31'(sum);
  endfunction

  logic [30:0] rom [DEPTH+2];

  for (genvar g = 0; g < DEPTH + 2; g++) begin : g_rom
    assign rom[g] = sine_entry(g);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= rom[k];
      s1 <= rom[k + KW'(1)];
    end
  end

endmodule

// ----- rtl/eci_back.sv -----
// Evaluation pipeline: progress divide, curve evaluation, bounce divide, scaling.
module eci_back #(
  parameter int FRAC_BITS      = eci_pkg::FRAC_BITS_DEF,
  parameter int SINE_ROM_DEPTH = eci_pkg::SINE_ROM_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  eci_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  input  eci_pkg::item_t                     item,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [eci_pkg::VALUE_W-1:0] eased_value
);

  localparam int F   = FRAC_BITS;
  localparam int EW  = F + 2;
  localparam int NW  = F + 16;
  localparam int KW  = $clog2(SINE_ROM_DEPTH + 2);
  localparam int PW  = F + KW;
  localparam int AW  = eci_pkg::AMP_W;
  localparam int PRW = AW + EW + 1;
  localparam int BW  = eci_pkg::BDEN_W;
  localparam int VW  = eci_pkg::VALUE_W;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // bounce numerators stay below 1805*ONE, so below 2^RS
  localparam int RS = F + 12;
  localparam int RW = F + 9;
  localparam logic [RW-1:0] RCP_16   = RW'((64'd1 << RS) / 64'd16);
  localparam logic [RW-1:0] RCP_40   = RW'((64'd1 << RS) / 64'd40);
  localparam logic [RW-1:0] RCP_1805 = RW'((64'd1 << RS) / 64'd1805);
  localparam logic [RW-1:0] RCP_25   = RW'((64'd1 << RS) / 64'd25);

  logic adv;
  assign adv = !result_valid || !result_stall;
  assign pop = adv && in_valid;

  // progress divide
  logic         d1_valid;
  logic [F-1:0] d1_p;
  logic [1:0]   d1_kind;

  eci_div #(.DW(eci_pkg::FRAME_W), .QB(F), .SW(2)) u_div_prog (
    .clk(clk), .rst(rst), .en(adv), .in_valid(in_valid),
    .num_hi(item.offset), .num_lo('0), .den(item.span), .side_in(item.kind),
    .out_valid(d1_valid), .quo(d1_p), .side_out(d1_kind)
  );

  // S1: squares and sine index
  logic          s1_valid;
  logic [1:0]    s1_kind;
  logic [F-1:0]  s1_p;
  logic [F:0]    s1_q;
  logic [F-1:0]  s1_sp;
  logic [F:0]    s1_sq;
  logic [KW-1:0] s1_k;
  logic [F-1:0]  s1_t;

  logic [F:0]     q1;
  logic [2*F-1:0] pp1;
  logic [2*F+1:0] qq1;
  logic [PW-1:0]  pos1;

  assign q1   = ONE - {1'b0, d1_p};
  assign pp1  = d1_p * d1_p;
  assign qq1  = q1 * q1;
  assign pos1 = PW'(q1) * PW'(SINE_ROM_DEPTH);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= d1_kind;
      s1_p    <= d1_p;
      s1_q    <= q1;
      s1_sp   <= pp1[2*F-1:F];
      s1_sq   <= qq1[2*F:F];
      s1_k    <= pos1[F +: KW];
      s1_t    <= pos1[F-1:0];
    end
  end

  // S2: cube products, sine lookup, bounce numerator
  logic           s2_valid;
  logic [1:0]     s2_kind;
  logic [F-1:0]   s2_p;
  logic [F:0]     s2_q;
  logic [F-1:0]   s2_t;
  logic [2*F-1:0] s2_cp;
  logic [2*F+1:0] s2_cq;
  logic [NW-1:0]  s2_num;
  logic [BW-1:0]  s2_den;
  logic [RW-1:0]  s2_rcp;
  logic [30:0]    rom_s0;
  logic [30:0]    rom_s1;

  eci_sine_rom #(.DEPTH(SINE_ROM_DEPTH), .KW(KW)) u_sine (
    .clk(clk), .en(adv), .k(s1_k), .s0(rom_s0), .s1(rom_s1)
  );

  logic [F+3:0]  p11;
  logic [F+3:0]  p10;
  logic [NW-1:0] b_pos;
  logic [NW-1:0] b_neg;
  logic [NW-1:0] b_num;
  logic [BW-1:0] b_den;
  logic [RW-1:0] b_rcp;

  assign p11 = (F+4)'(s1_p) * (F+4)'(11);
  assign p10 = (F+4)'(s1_p) * (F+4)'(10);

  always_comb begin
    // piecewise parabola segments of the bounce
    if (p11 < ((F+4)'(4) << F)) begin
      b_pos = NW'(121) * NW'(s1_sp);
      b_neg = '0;
      b_den = BW'(16);
      b_rcp = RCP_16;
    end else if (p11 < ((F+4)'(8) << F)) begin
      b_pos = NW'(363) * NW'(s1_sp) + (NW'(136) << F);
      b_neg = NW'(396) * NW'(s1_p);
      b_den = BW'(40);
      b_rcp = RCP_40;
    end else if (p10 < ((F+4)'(9) << F)) begin
      b_pos = NW'(21780) * NW'(s1_sp) + (NW'(16061) << F);
      b_neg = NW'(35442) * NW'(s1_p);
      b_den = BW'(1805);
      b_rcp = RCP_1805;
    end else begin
      b_pos = NW'(270) * NW'(s1_sp) + (NW'(268) << F);
      b_neg = NW'(513) * NW'(s1_p);
      b_den = BW'(25);
      b_rcp = RCP_25;
    end
    b_num = (b_pos > b_neg) ? b_pos - b_neg : '0;
    if (cfg.curve_mode != eci_pkg::MODE_BOUNCE_OUT) begin
      b_num = '0;
      b_den = BW'(16);
      b_rcp = RCP_16;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= s1_kind;
      s2_p    <= s1_p;
      s2_q    <= s1_q;
      s2_t    <= s1_t;
      s2_cp   <= s1_sp * s1_p;
      s2_cq   <= s1_sq * s1_q;
      s2_num  <= b_num;
      s2_den  <= b_den;
      s2_rcp  <= b_rcp;
    end
  end

  // S3: cubes and sine interpolation
  logic          s3_valid;
  logic [1:0]    s3_kind;
  logic [F-1:0]  s3_p;
  logic [F:0]    s3_q;
  logic [F-1:0]  s3_cube_p;
  logic [F:0]    s3_cube_q;
  logic [30:0]   s3_s;
  logic [NW-1:0] s3_num;
  logic [BW-1:0] s3_den;
  logic [RW-1:0] s3_rcp;

  logic signed [31:0]  s_diff;
  logic signed [32+F:0] s_prod;
  logic signed [32+F:0] s_adj;
  logic signed [32+F:0] s_sum;

  always_comb begin
    s_diff = $signed({1'b0, rom_s1}) - $signed({1'b0, rom_s0});
    s_prod = s_diff * $signed({1'b0, s2_t});
    s_adj  = s_prod;
    if (s_prod < 0) begin
      s_adj = s_prod + $signed((33+F)'({F{1'b1}}));
    end
    s_sum = $signed((33+F)'(rom_s0)) + (s_adj >>> F);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind   <= s2_kind;
      s3_p      <= s2_p;
      s3_q      <= s2_q;
      s3_cube_p <= s2_cp[2*F-1:F];
      s3_cube_q <= s2_cq[2*F:F];
      s3_s      <= s_sum[30:0];
      s3_num    <= s2_num;
      s3_den    <= s2_den;
      s3_rcp    <= s2_rcp;
    end
  end

  // S4: closed-form curves
  logic          s4_valid;
  logic [1:0]    s4_kind;
  logic [EW-1:0] s4_ease;
  logic [NW-1:0] s4_num;
  logic [BW-1:0] s4_den;
  logic [RW-1:0] s4_rcp;

  logic [F+31:0] qs;
  logic [EW-1:0] ease4;

  assign qs = (F+32)'(s3_q) * (F+32)'(s3_s);

  always_comb begin
    unique case (cfg.curve_mode)
      eci_pkg::MODE_CUBIC_INOUT: begin
        if (!s3_p[F-1]) begin
          ease4 = {s3_cube_p, 2'b00};
        end else begin
          ease4 = EW'(ONE) - EW'({s3_cube_q, 2'b00});
        end
      end
      eci_pkg::MODE_CUBIC_OUT: ease4 = EW'(ONE) - EW'(s3_cube_q);
      eci_pkg::MODE_BOUNCE_OUT: ease4 = '0;
      eci_pkg::MODE_BACK_OUT: ease4 = EW'(ONE) - EW'(s3_cube_q) + qs[30 +: EW];
      default: ease4 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_kind <= s3_kind;
      s4_ease <= ease4;
      s4_num  <= s3_num;
      s4_den  <= s3_den;
      s4_rcp  <= s3_rcp;
    end
  end

  // bounce divide: reciprocal multiply lands at or one below the quotient
  logic          r1_valid;
  logic [1:0]    r1_kind;
  logic [EW-1:0] r1_ease;
  logic [RS-1:0] r1_num;
  logic [BW-1:0] r1_den;
  logic [EW-1:0] r1_quo;

  logic [RS+RW-1:0] rcp_prod;

  assign rcp_prod = s4_num[RS-1:0] * s4_rcp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_kind <= s4_kind;
      r1_ease <= s4_ease;
      r1_num  <= s4_num[RS-1:0];
      r1_den  <= s4_den;
      r1_quo  <= rcp_prod[RS +: EW];
    end
  end

  // one correction step, other curves ride along as side data
  logic          d2_valid;
  logic [EW-1:0] d2_quo;
  logic [EW+1:0] d2_side;

  logic [EW+BW-1:0] r1_back;
  logic [RS-1:0]    r1_rem;

  assign r1_back = r1_quo * r1_den;
  assign r1_rem  = r1_num - r1_back[RS-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_side <= {r1_kind, r1_ease};
      d2_quo  <= (r1_rem >= RS'(r1_den)) ? r1_quo + 1'b1 : r1_quo;
    end
  end

  // S5: amplitude scaling
  logic                  s5_valid;
  logic [1:0]            s5_kind;
  logic signed [PRW-1:0] s5_prod;
  logic [EW-1:0]         ease_sel;

  assign ease_sel = (cfg.curve_mode == eci_pkg::MODE_BOUNCE_OUT) ? d2_quo[EW-1:0]
                                                                  : d2_side[EW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_kind <= d2_side[EW+1:EW];
      s5_prod <= $signed(cfg.amplitude) * $signed({1'b0, ease_sel});
    end
  end

  // S6: truncate toward zero, saturate, output register
  logic signed [PRW-1:0] r_adj;
  logic signed [PRW-1:0] r_sh;
  logic [VW-1:0]         r_sat;

  always_comb begin
    r_adj = s5_prod;
    if (s5_prod < 0) begin
      r_adj = s5_prod + $signed(PRW'({F{1'b1}}));
    end
    r_sh = r_adj >>> F;
    if (r_sh[PRW-1:VW-1] == '0 || r_sh[PRW-1:VW-1] == '1) begin
      r_sat = r_sh[VW-1:0];
    end else if (r_sh[PRW-1]) begin
      r_sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r_sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case (s5_kind)
        eci_pkg::KIND_FULL: eased_value <= {cfg.amplitude[AW-1], cfg.amplitude};
        eci_pkg::KIND_ZERO: eased_value <= '0;
        default:            eased_value <= r_sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      r1_valid     <= 1'b0;
      d2_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= d1_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      r1_valid     <= s4_valid;
      d2_valid     <= r1_valid;
      s5_valid     <= d2_valid;
      result_valid <= s5_valid;
    end
  end

`ifndef SYNTHESIS
  ast_ease_bound: assert property (@(posedge clk) disable iff (rst)
      (d2_valid && d2_side[EW+1:EW] == eci_pkg::KIND_INTERP) |-> (ease_sel < (EW'(ONE) << 1)))
    else $error("eased progress out of range");
  ast_bounce_num_fits: assert property (@(posedge clk) disable iff (rst)
      s4_valid |-> (s4_num[NW-1:RS] == '0))
    else $error("bounce numerator too wide for reciprocal divide");
`endif

endmodule

// ----- rtl/easing_curve_interpolator.sv -----
// Top level of the easing curve interpolator: register port, front end, queue, pipeline.
//
// Returns amplitude * ease(progress) for each frame number, where progress is the
// fraction of the way from start_frame to end_frame and the curve is cubic in-out,
// cubic out, bounce out or back out (curve_mode 0..3). Frames at or past end_frame
// give the full amplitude, frames at or before start_frame give zero; results are
// signed Q16.16 saturated to 32 bits. One frame is accepted per clock while the queue is
// not full, and results leave in order, one per clock unless stalled. From the queue head
// an item passes FRAC_BITS stages of the progress divider, four curve stages, two
// bounce-segment divide stages (reciprocal multiply, then one correction step) and two
// scaling and saturation stages. A four-item queue lets frames keep arriving while the
// result side is stalled; the pipeline holds still while result_stall is high and a
// result is waiting.
// Registers are written over the APB-style port at byte addresses 0, 4, 8 and 12
// (start_frame, end_frame, amplitude, curve_mode) and must only change while no
// item is in flight.
module easing_curve_interpolator #(
  parameter int FRAC_BITS      = eci_pkg::FRAC_BITS_DEF,
  parameter int SINE_ROM_DEPTH = eci_pkg::SINE_ROM_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [eci_pkg::ADDR_W-1:0]         paddr,
  input  logic [eci_pkg::DATA_W-1:0]         pwdata,
  output logic [eci_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // frame items in
  input  logic                               frame_valid,
  output logic                               frame_stall,
  input  logic [eci_pkg::FRAME_W-1:0]        frame_now,
  // result items out
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [eci_pkg::VALUE_W-1:0] eased_value
);

  eci_pkg::cfg_t cfg;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // register writes land on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        eci_pkg::REG_START_FRAME: cfg.start_frame <= pwdata[eci_pkg::FRAME_W-1:0];
        eci_pkg::REG_END_FRAME:   cfg.end_frame   <= pwdata[eci_pkg::FRAME_W-1:0];
        eci_pkg::REG_AMPLITUDE:   cfg.amplitude   <= pwdata[eci_pkg::AMP_W-1:0];
        eci_pkg::REG_CURVE_MODE:  cfg.curve_mode  <= pwdata[eci_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eci_pkg::REG_START_FRAME: prdata = eci_pkg::DATA_W'(cfg.start_frame);
      eci_pkg::REG_END_FRAME:   prdata = eci_pkg::DATA_W'(cfg.end_frame);
      eci_pkg::REG_AMPLITUDE:   prdata = eci_pkg::DATA_W'(cfg.amplitude);
      eci_pkg::REG_CURVE_MODE:  prdata = eci_pkg::DATA_W'(cfg.curve_mode);
      default:                  prdata = '0;
    endcase
  end

  // front end classifies, queue decouples, back end evaluates
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  eci_pkg::item_t q_in;
  eci_pkg::item_t q_out;

  eci_front u_front (
    .frame_valid(frame_valid),
    .frame_now(frame_now),
    .cfg(cfg),
    .queue_full(q_full),
    .frame_stall(frame_stall),
    .push(q_push),
    .item(q_in)
  );

  eci_fifo u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .item_in(q_in),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .item_out(q_out)
  );

  eci_back #(
    .FRAC_BITS(FRAC_BITS),
    .SINE_ROM_DEPTH(SINE_ROM_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(q_valid),
    .item(q_out),
    .pop(q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .eased_value(eased_value)
  );

endmodule
